FILE: sv/dcs_pkg.sv
// Shared types, codes and constants for the DDS command serializer.
// Used by every module of the block; depends on nothing.
package dcs_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int ADDR_W = 5;
	localparam int VALUE_W = 32;
	localparam int DATA_W = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam int QUO_W = 33;
	localparam int LEN_W = 6;
	localparam int REG_FRAME_W = 40;
	localparam int WORD_W = 56;

	localparam int MUL_X_W = 29;
	localparam int PHASE_IN_W = 9;
	localparam int RECIP_HI_W = 26;
	localparam int RECIP_LO_W = 22;
	localparam int FREQ_RECIP_SPLIT = 27;
	localparam int PROD_W = 82;
	localparam int FREQ_SHIFT = 49;
	localparam int PHASE_SHIFT = 14;

	localparam logic [VALUE_W-1:0] FREQ_MAX_HZ = 32'd500000000;
	localparam logic [VALUE_W-1:0] FREQ_SUBST = 32'd114514;
	localparam logic [VALUE_W-1:0] AMP_MAX = 32'd1023;
	localparam logic [VALUE_W-1:0] AMP_SUBST = 32'd114;
	localparam logic [15:0] AMP_ENABLE = 16'h1000;
	localparam logic [VALUE_W-1:0] PHASE_TOP_DEG = 32'd359;
	localparam logic [7:0] SELECT_BASE = 8'h10;

	// The frequency word is x * ceil(2^73 / 1953125) >> 49, split into two partial products.
	localparam logic [RECIP_HI_W-1:0] FREQ_RECIP_HI = 26'd36028797;
	localparam logic [RECIP_LO_W-1:0] FREQ_RECIP_LO = 22'd2545301;
	// The phase word is p * ceil(2^25 / 45) >> 14, exact for p up to 359.
	localparam logic [RECIP_LO_W-1:0] PHASE_RECIP = 22'd745655;

	localparam logic [LEN_W-1:0] LEN_FREQ = 6'd40;
	localparam logic [LEN_W-1:0] LEN_AMP = 6'd32;
	localparam logic [LEN_W-1:0] LEN_PHASE = 6'd24;
	localparam logic [LEN_W-1:0] LEN_SELECT = 6'd16;

	localparam logic [ADDR_W-1:0] RST_ADDR_CHAN_SEL = 5'd0;
	localparam logic [ADDR_W-1:0] RST_ADDR_FREQ = 5'd4;
	localparam logic [ADDR_W-1:0] RST_ADDR_PHASE = 5'd5;
	localparam logic [ADDR_W-1:0] RST_ADDR_AMP = 5'd6;

	typedef enum logic [1:0] {
		FUNC_FREQ = 2'd0,
		FUNC_AMP = 2'd1,
		FUNC_PHASE = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_CHAN_SEL = 2'd0,
		REG_FREQ = 2'd1,
		REG_PHASE = 2'd2,
		REG_AMP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_FIN
	} front_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] chan_sel;
		logic [ADDR_W-1:0] freq;
		logic [ADDR_W-1:0] phase;
		logic [ADDR_W-1:0] amp;
	} addr_cfg_t;

	typedef struct packed {
		logic has_sel;
		logic [7:0] sel_byte;
		logic [ADDR_W-1:0] sel_addr;
		logic [ADDR_W-1:0] reg_addr;
		func_t func;
		logic [DATA_W-1:0] data;
		logic [1:0] err;
	} cmd_t;

endpackage

FILE: sv/dcs_divider.sv
// Two-stage reciprocal multiplier that divides by the frequency and phase constants.
// Used by dcs_front for the frequency and phase words; depends on dcs_pkg.
module dcs_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          is_freq,
	input  logic [dcs_pkg::MUL_X_W-1:0]   value,
	output logic                          last_step,
	output logic [dcs_pkg::QUO_W-1:0]     quotient
);
	import dcs_pkg::*;

	logic valid_s1;
	logic freq_s1;
	logic [MUL_X_W+RECIP_HI_W-1:0] hi_s1;
	logic [MUL_X_W+RECIP_LO_W-1:0] lo_s1;
	logic [QUO_W-1:0] quo_q;

	logic [MUL_X_W-1:0] mul_x;
	logic [RECIP_LO_W-1:0] lo_k;
	logic [PROD_W-1:0] prod;

	always_comb begin
		mul_x = is_freq ? value : {{(MUL_X_W-PHASE_IN_W){1'b0}}, value[PHASE_IN_W-1:0]};
		lo_k = is_freq ? FREQ_RECIP_LO : PHASE_RECIP;
		prod = {hi_s1, {FREQ_RECIP_SPLIT{1'b0}}} + PROD_W'(lo_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			freq_s1 <= is_freq;
			hi_s1 <= is_freq ? mul_x * FREQ_RECIP_HI : '0;
			lo_s1 <= mul_x * lo_k;
		end
		if (valid_s1) begin
			quo_q <= freq_s1 ? prod[PROD_W-1:FREQ_SHIFT]
				: lo_s1[QUO_W+PHASE_SHIFT-1:PHASE_SHIFT];
		end
	end

	assign last_step = valid_s1;
	assign quotient = quo_q;

endmodule

FILE: sv/dcs_front.sv
// Front end: accepts commands, checks ranges and channel, builds queue entries.
// Runs the reciprocal multiplier for frequency and phase words; depends on dcs_pkg and dcs_divider.
module dcs_front #(
	parameter int CHANNELS = dcs_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    func,
	input  logic [2:0]                    channel,
	input  logic [dcs_pkg::VALUE_W-1:0]   value,
	input  dcs_pkg::addr_cfg_t            cfg,
	input  logic                          queue_full,
	output logic                          busy,
	output logic                          push,
	output dcs_pkg::cmd_t                 push_cmd
);
	import dcs_pkg::*;

	front_state_t state_q, state_d;
	cmd_t pend_q;
	cmd_t new_cmd;
	func_t f;
	logic accept;
	logic chan_ok;
	logic val_bad;
	logic [VALUE_W-1:0] val_sub;
	logic [ADDR_W-1:0] reg_addr;
	logic div_load;
	logic div_is_freq;
	logic div_last;
	logic [QUO_W-1:0] quotient;
	logic [DATA_W-1:0] div_data;

	always_comb begin
		f = func_t'(func);
		chan_ok = {1'b0, channel} < 4'(CHANNELS);
		unique case (f)
			FUNC_FREQ: begin
				val_bad = (value == '0) || (value > FREQ_MAX_HZ);
				val_sub = val_bad ? FREQ_SUBST : value;
				reg_addr = cfg.freq;
			end
			FUNC_AMP: begin
				val_bad = value > AMP_MAX;
				val_sub = val_bad ? AMP_SUBST : value;
				reg_addr = cfg.amp;
			end
			FUNC_PHASE: begin
				val_bad = value > PHASE_TOP_DEG;
				val_sub = val_bad ? '0 : value;
				reg_addr = cfg.phase;
			end
			default: begin
				val_bad = 1'b0;
				val_sub = value;
				reg_addr = cfg.amp;
			end
		endcase
		new_cmd.has_sel = chan_ok;
		new_cmd.sel_byte = SELECT_BASE << channel;
		new_cmd.sel_addr = cfg.chan_sel;
		new_cmd.reg_addr = reg_addr;
		new_cmd.func = f;
		new_cmd.data = {16'h0000, val_sub[15:0] | AMP_ENABLE};
		new_cmd.err = {~chan_ok, val_bad};
	end

	always_comb begin
		accept = start && !busy;
		div_load = accept && ((f == FUNC_FREQ) || (f == FUNC_PHASE));
		div_is_freq = f == FUNC_FREQ;
	end

	dcs_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (div_load),
		.is_freq   (div_is_freq),
		.value     (val_sub[MUL_X_W-1:0]),
		.last_step (div_last),
		.quotient  (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= new_cmd;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (div_load) begin
					state_d = FS_DIV;
				end
			end
			FS_DIV: begin
				if (div_last) begin
					state_d = FS_FIN;
				end
			end
			FS_FIN: begin
				state_d = FS_IDLE;
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_comb begin
		if (pend_q.func == FUNC_FREQ) begin
			div_data = quotient[QUO_W-1] ? '1 : quotient[DATA_W-1:0];
		end else begin
			div_data = {16'h0000, quotient[15:0]};
		end
		busy = (state_q != FS_IDLE) || queue_full;
		push = 1'b0;
		push_cmd = new_cmd;
		unique case (state_q)
			FS_IDLE: begin
				push = accept && (f == FUNC_AMP);
			end
			FS_FIN: begin
				push = 1'b1;
				push_cmd = pend_q;
				push_cmd.data = div_data;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/dcs_queue.sv
// Short queue of prepared frame commands between the front and the back end.
// Depends on dcs_pkg for the entry type.
module dcs_queue #(
	parameter int DEPTH = dcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dcs_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          nonempty,
	output dcs_pkg::cmd_t head
);
	import dcs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign do_pop = pop && nonempty;
	assign do_push = push && (!full || do_pop);
	assign full = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: sv/dcs_back.sv
// Back end: turns a queued command into its frames and shifts them out one bit a clock.
// Depends on dcs_pkg.
module dcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nonempty,
	input  dcs_pkg::cmd_t head,
	output logic          pop,
	output logic          strobe,
	output logic          sdio_bit,
	output logic          frame_end,
	output logic [1:0]    error_code,
	output logic          last
);
	import dcs_pkg::*;

	logic [WORD_W-1:0] sh_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] reg_len_q;
	logic has_sel_q;
	logic [1:0] err_q;

	logic [REG_FRAME_W-1:0] reg_frame;
	logic [LEN_W-1:0] reg_len;
	logic [WORD_W-1:0] word;
	logic [LEN_W-1:0] total;

	always_comb begin
		unique case (head.func)
			FUNC_AMP: begin
				reg_frame = {3'b000, head.reg_addr, 8'h00, head.data[15:0], 8'h00};
				reg_len = LEN_AMP;
			end
			FUNC_PHASE: begin
				reg_frame = {3'b000, head.reg_addr, head.data[15:0], 16'h0000};
				reg_len = LEN_PHASE;
			end
			default: begin
				reg_frame = {3'b000, head.reg_addr, head.data};
				reg_len = LEN_FREQ;
			end
		endcase
		if (head.has_sel) begin
			word = {3'b000, head.sel_addr, head.sel_byte, reg_frame};
			total = reg_len + LEN_SELECT;
		end else begin
			word = {reg_frame, 16'h0000};
			total = reg_len;
		end
	end

	assign pop = nonempty && (cnt_q <= LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= total;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= word;
			reg_len_q <= reg_len;
			has_sel_q <= head.has_sel;
			err_q <= head.err;
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[WORD_W-2:0], 1'b0};
		end
	end

	assign strobe = cnt_q != '0;
	assign sdio_bit = sh_q[WORD_W-1];
	assign last = cnt_q == LEN_W'(1);
	assign frame_end = last || (has_sel_q && (cnt_q == reg_len_q + LEN_W'(1)));
	assign error_code = err_q;

endmodule

FILE: sv/dds_command_serializer.sv
// Top level of the DDS command serializer: configuration registers and block wiring.
// Depends on dcs_pkg, dcs_front, dcs_queue and dcs_back.
//
// A command (func, channel, value) is taken at a rising edge with start high and
// busy low. Its serial bits leave MSB first, one per clock, each shown for exactly
// one cycle while strobe is high, with sdio_bit, frame_end, error_code and last.
// A valid channel gets a 16-bit select frame before the register frame; the
// register frame is 40, 32 or 24 bits for frequency, amplitude and phase.
// Func 3 is taken and produces nothing.
// Frequency and phase commands pass through a two-stage reciprocal multiplier in the
// front end before they are pushed into the queue; amplitude commands go straight to
// the queue.
// Throughput: the serial line sends one bit per clock, with no gap between commands
// while the queue holds the next one; the queue (two entries by default) lets the
// front end prepare the next command meanwhile. busy stays high after a frequency or
// phase command is taken until it has been pushed, and whenever the queue is full.
// The receiver cannot stall: every bit is delivered in the cycle it is shown.
// Reset clears the queue, the shift counter and the front state; the address
// registers return to 0, 4, 5 and 6 and sit at APB byte addresses 0, 4, 8 and 12,
// always ready; the user must write them only while the block is idle (not enforced).
module dds_command_serializer #(
	parameter int CHANNELS = dcs_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = dcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [2:0]                      channel,
	input  logic [dcs_pkg::VALUE_W-1:0]     value,
	output logic                            strobe,
	output logic                            sdio_bit,
	output logic                            frame_end,
	output logic [1:0]                      error_code,
	output logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dcs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dcs_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dcs_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import dcs_pkg::*;

	addr_cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic cfg_write;
	logic [ADDR_W-1:0] rd_val;

	logic push;
	cmd_t push_cmd;
	logic pop;
	logic queue_full;
	logic queue_nonempty;
	cmd_t head;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_sel <= RST_ADDR_CHAN_SEL;
			cfg_q.freq <= RST_ADDR_FREQ;
			cfg_q.phase <= RST_ADDR_PHASE;
			cfg_q.amp <= RST_ADDR_AMP;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_CHAN_SEL: cfg_q.chan_sel <= pwdata[ADDR_W-1:0];
				REG_FREQ: cfg_q.freq <= pwdata[ADDR_W-1:0];
				REG_PHASE: cfg_q.phase <= pwdata[ADDR_W-1:0];
				REG_AMP: cfg_q.amp <= pwdata[ADDR_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHAN_SEL: rd_val = cfg_q.chan_sel;
			REG_FREQ: rd_val = cfg_q.freq;
			REG_PHASE: rd_val = cfg_q.phase;
			REG_AMP: rd_val = cfg_q.amp;
			default: rd_val = '0;
		endcase
		prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, rd_val};
	end

	dcs_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.channel    (channel),
		.value      (value),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.busy       (busy),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	dcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.nonempty (queue_nonempty),
		.head     (head)
	);

	dcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (queue_nonempty),
		.head       (head),
		.pop        (pop),
		.strobe     (strobe),
		.sdio_bit   (sdio_bit),
		.frame_end  (frame_end),
		.error_code (error_code),
		.last       (last)
	);

endmodule

FILE: sv/dcs_checker.sv
// Port-level checks for the DDS command serializer, bound to the top level.
// Depends on dcs_pkg and on the port names of dds_command_serializer.
module dcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       strobe,
	input logic       frame_end,
	input logic [1:0] error_code,
	input logic       last,
	input logic       pready
);
	import dcs_pkg::*;

	// The final beat of a command always closes a frame.
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> frame_end)
		else $error("last beat without frame_end");

	// Beats of one command are contiguous and share one error code.
	a_command_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> (strobe && error_code == $past(error_code)))
		else $error("command beats broken or error_code changed");

	// An amplitude command taken while the line is quiet starts sending once it has passed through the queue.
	a_amp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_AMP && !strobe) |-> ##2 strobe)
		else $error("amplitude command did not start on time");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind dds_command_serializer dcs_checker u_dcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.strobe     (strobe),
	.frame_end  (frame_end),
	.error_code (error_code),
	.last       (last),
	.pready     (pready)
);
